FILE: hw/rtl/tcmms_pkg.sv
// Shared types and constants for the three-channel min/max calibrated scaler.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package tcmms_pkg;

   // Item kinds carried in the kind field of a request beat.
   localparam logic [1:0] KIND_SET   = 2'd0;
   localparam logic [1:0] KIND_TRACK = 2'd1;
   localparam logic [1:0] KIND_SCALE = 2'd2;

   // Number of sensor channels; channel codes at or above this are ignored.
   localparam logic [1:0] NUM_CHANNELS = 2'd3;

   // Full-scale reading and its form as a multiplier operand.
   localparam logic [6:0]        FULL_SCALE = 7'd100;
   localparam logic signed [23:0] SCALE_MUL = 24'sd100;

   // The quotient is 7 bits wide, one bit per divider step.
   localparam int DIV_STEPS = 7;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

   // Request beat payload.
   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         channel;
      logic signed [15:0] sample;
      logic signed [15:0] bound_low;
      logic signed [15:0] bound_high;
   } req_type;

   // Response beat payload.
   typedef struct packed {
      logic [6:0] percent;
      logic       range_error;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SETUP,
      ST_DIV,
      ST_FIN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic prep;
      logic setup;
      logic step;
      logic finish;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
   } dp_sts_type;

endpackage

FILE: hw/rtl/tcmms_dp.sv
// Datapath of the calibrated scaler: item register, calibration bounds,
// scale-factor multiply, restoring divider and response register.
// Depends on tcmms_pkg.
module tcmms_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  tcmms_pkg::req_type    req_data,
   input  tcmms_pkg::dp_cmd_type cmd,
   output tcmms_pkg::dp_sts_type sts,
   output tcmms_pkg::rsp_type    rsp_data
);

   tcmms_pkg::req_type item_ff;
   logic signed [15:0] lower_ff [3];
   logic signed [15:0] upper_ff [3];

   logic signed [23:0] num_ff;
   logic signed [16:0] den_ff;
   logic               div_ff;
   logic               err_ff;
   logic               neg_ff;
   logic               sat_ff;
   logic [22:0]        rem_ff;
   logic [22:0]        dsr_ff;
   logic [6:0]         quo_ff;
   tcmms_pkg::rsp_type  rsp_ff;

   logic               chan_ok;
   logic signed [15:0] lo_sel;
   logic signed [15:0] hi_sel;
   logic signed [16:0] diff;
   logic signed [16:0] dev;
   logic signed [23:0] num_in;
   logic [23:0]        num_neg;
   logic [16:0]        den_neg;
   logic [22:0]        num_abs;
   logic [15:0]        den_abs;
   logic               is_scale;
   logic [22:0]        rem_in;
   logic [6:0]         quo_in;
   logic [6:0]         pct_in;
   tcmms_pkg::rsp_type  rsp_in;

   // Item register, loaded on an accepted request beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   // Bounds of the addressed channel.
   assign chan_ok = (item_ff.channel < tcmms_pkg::NUM_CHANNELS);

   always_comb begin
      case (item_ff.channel)
         2'd0: begin
            lo_sel = lower_ff[0];
            hi_sel = upper_ff[0];
         end
         2'd1: begin
            lo_sel = lower_ff[1];
            hi_sel = upper_ff[1];
         end
         2'd2: begin
            lo_sel = lower_ff[2];
            hi_sel = upper_ff[2];
         end
         default: begin
            lo_sel = '0;
            hi_sel = '0;
         end
      endcase
   end

   // Difference terms and the scaled numerator.
   assign diff   = {hi_sel[15], hi_sel} - {lo_sel[15], lo_sel};
   assign dev    = {item_ff.sample[15], item_ff.sample} - {lo_sel[15], lo_sel};
   assign num_in = $signed({{7{dev[16]}}, dev}) * tcmms_pkg::SCALE_MUL;

   assign is_scale = (item_ff.kind == tcmms_pkg::KIND_SCALE) && chan_ok;
   assign sts.need_div = is_scale && (lo_sel != hi_sel);

   // Calibration bounds: loaded by a set beat, widened by a tracking beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            lower_ff[i] <= '0;
            upper_ff[i] <= '0;
         end
      end else if (cmd.prep && chan_ok) begin
         for (int i = 0; i < 3; i++) begin
            if (item_ff.channel == 2'(i)) begin
               if (item_ff.kind == tcmms_pkg::KIND_SET) begin
                  lower_ff[i] <= item_ff.bound_low;
                  upper_ff[i] <= item_ff.bound_high;
               end else if (item_ff.kind == tcmms_pkg::KIND_TRACK) begin
                  if (item_ff.sample < lower_ff[i]) begin
                     lower_ff[i] <= item_ff.sample;
                  end else if (item_ff.sample > upper_ff[i]) begin
                     upper_ff[i] <= item_ff.sample;
                  end
               end
            end
         end
      end
   end

   // Operand register after the multiply.
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         num_ff <= num_in;
         den_ff <= diff;
         div_ff <= sts.need_div;
         err_ff <= is_scale && (lo_sel == hi_sel);
      end
   end

   // Magnitudes, sign of the quotient and the saturation test.
   assign num_neg = -num_ff;
   assign den_neg = -den_ff;
   assign num_abs = num_ff[23] ? num_neg[22:0] : num_ff[22:0];
   assign den_abs = den_ff[16] ? den_neg[15:0] : den_ff[15:0];

   // Restoring divide step: one quotient bit per cycle.
   always_comb begin
      if (rem_ff >= dsr_ff) begin
         rem_in = rem_ff - dsr_ff;
         quo_in = {quo_ff[5:0], 1'b1};
      end else begin
         rem_in = rem_ff;
         quo_in = {quo_ff[5:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         neg_ff <= num_ff[23] ^ den_ff[16];
         sat_ff <= ({1'b0, num_abs[22:7]} >= {1'b0, den_abs});
         rem_ff <= num_abs;
         dsr_ff <= {1'b0, den_abs, 6'b0};
         quo_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         dsr_ff <= {1'b0, dsr_ff[22:1]};
         quo_ff <= quo_in;
      end
   end

   // Clamp to the 0..100 range and form the response.
   always_comb begin
      if (!div_ff || neg_ff) begin
         pct_in = '0;
      end else if (sat_ff || (quo_ff > tcmms_pkg::FULL_SCALE)) begin
         pct_in = tcmms_pkg::FULL_SCALE;
      end else begin
         pct_in = quo_ff;
      end
      rsp_in.percent     = pct_in;
      rsp_in.range_error = err_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/tcmms_ctrl.sv
// Controller of the calibrated scaler: sequencing state machine, divider
// step counter and response valid flag.
// Depends on tcmms_pkg.
module tcmms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tcmms_pkg::dp_sts_type sts,
   output tcmms_pkg::dp_cmd_type cmd
);

   tcmms_pkg::state_type        state_ff;
   tcmms_pkg::state_type        state_in;
   logic [tcmms_pkg::CNT_W-1:0] cnt_ff;
   logic [tcmms_pkg::CNT_W-1:0] cnt_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       slot_free;

   // State, counter and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcmms_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response register can take a new result if it is empty or draining.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         tcmms_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = tcmms_pkg::ST_PREP;
            end
         end
         tcmms_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = sts.need_div ? tcmms_pkg::ST_SETUP : tcmms_pkg::ST_FIN;
         end
         tcmms_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = tcmms_pkg::ST_DIV;
         end
         tcmms_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == tcmms_pkg::LAST_STEP) begin
               state_in = tcmms_pkg::ST_FIN;
            end
         end
         tcmms_pkg::ST_FIN: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tcmms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcmms_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/three_channel_minmax_calibrated_scaler.sv
// Top level of the three-channel min/max calibrated scaler.
// Instantiates tcmms_ctrl and tcmms_dp; depends on tcmms_pkg.
//
//  Channel   Direction  Handshake              Beat payload
//  req_      in         req_valid / req_ready  tcmms_pkg::req_type
//  rsp_      out        rsp_valid / rsp_ready  tcmms_pkg::rsp_type
//
// A scale beat passes from acceptance to a valid response through these steps:
// reading the bounds and multiplying by 100, forming magnitudes, seven steps of
// the restoring divider and clamping; set and tracking beats skip the middle two.
// The block is ready for a new beat in the cycle after the result is registered.
// Reset is synchronous and clears the bounds of all channels to zero.
// A stalled response holds in its register while the next beat is accepted and
// worked on; that beat then waits in its final state until the register drains.
module three_channel_minmax_calibrated_scaler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcmms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcmms_pkg::rsp_type rsp_data
);

   tcmms_pkg::dp_cmd_type cmd;
   tcmms_pkg::dp_sts_type sts;

   // Sequencing.
   tcmms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Bounds, arithmetic and response register.
   tcmms_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hw/rtl/tcmms_chk.sv
// Port-level checker for the calibrated scaler, bound to the top level.
// Depends on tcmms_pkg and three_channel_minmax_calibrated_scaler.
module tcmms_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tcmms_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tcmms_pkg::rsp_type rsp_data
);

   // A stalled response beat stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A percentage never exceeds full scale.
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.percent <= tcmms_pkg::FULL_SCALE))
      else $error("percent above full scale");

   // A range error always carries a zero reading.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_error |-> (rsp_data.percent == 7'd0))
      else $error("range error with non-zero percent");

   // One beat is worked on at a time: the block is busy after accepting one.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind three_channel_minmax_calibrated_scaler tcmms_chk u_tcmms_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: dv/three_channel_minmax_calibrated_scaler_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the three-channel min/max calibrated scaler testbench.
// Watches the request and response channels, keeps its own copy of the calibration
// bounds and checks every response beat in order. Depends on tcmms_pkg.
module three_channel_minmax_calibrated_scaler_checker
   import tcmms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      checked_count
);

   localparam int REPORT_LIMIT = 10;

   // Calibration bounds as the block should hold them.
   logic signed [15:0] lower_bound [3];
   logic signed [15:0] upper_bound [3];

   // Responses still owed by the block, oldest first.
   rsp_type awaited_rsp [$];

   // Applies one request beat to the bound copies and returns the response it owes.
   function automatic rsp_type scale_and_track(input req_type beat);
      rsp_type res;
      int      ch;
      int      lo;
      int      hi;
      int      reading;
      int      quotient;
      res     = '0;
      ch      = int'(beat.channel);
      reading = int'($signed(beat.sample));
      if (beat.channel < NUM_CHANNELS) begin
         lo = int'(lower_bound[ch]);
         hi = int'(upper_bound[ch]);
         case (beat.kind)
            KIND_SET: begin
               lower_bound[ch] = beat.bound_low;
               upper_bound[ch] = beat.bound_high;
            end
            KIND_TRACK: begin
               // A lower reading wins; the upper bound only moves otherwise.
               if (reading < lo) begin
                  lower_bound[ch] = beat.sample;
               end else if (reading > hi) begin
                  upper_bound[ch] = beat.sample;
               end
            end
            KIND_SCALE: begin
               if (lo == hi) begin
                  res.range_error = 1'b1;
               end else begin
                  // Integer division truncates toward zero, as the block must.
                  quotient = ((reading - lo) * int'(FULL_SCALE)) / (hi - lo);
                  if (quotient < 0) quotient = 0;
                  if (quotient > int'(FULL_SCALE)) quotient = int'(FULL_SCALE);
                  res.percent = 7'(quotient);
               end
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   // Beats are taken at the rising edge; responses are matched before new requests
   // are queued, since a response never belongs to a request of the same edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            lower_bound[i] = '0;
            upper_bound[i] = '0;
         end
         awaited_rsp.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: response beat with none outstanding: percent %0d range_error %0b",
                           $time, rsp_data.percent, rsp_data.range_error);
               end
            end else begin
               want = awaited_rsp.pop_front();
               checked_count++;
               if (rsp_data.percent !== want.percent ||
                   rsp_data.range_error !== want.range_error) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch: percent exp %0d got %0d, range_error exp %0b got %0b",
                              $time, want.percent, rsp_data.percent,
                              want.range_error, rsp_data.range_error);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_rsp.push_back(scale_and_track(req_data));
         end
      end
      pending_count = awaited_rsp.size();
   end

endmodule

FILE: dv/three_channel_minmax_calibrated_scaler_test.sv
`timescale 1ns / 1ps
// Top of the testbench for the three-channel min/max calibrated scaler.
// Drives directed and random request beats with random stalls on both channels;
// checking is done by three_channel_minmax_calibrated_scaler_checker. Uses tcmms_pkg.
module three_channel_minmax_calibrated_scaler_test;
   import tcmms_pkg::*;

   // Codes the block must ignore.
   localparam logic [1:0] KIND_SPARE    = 2'd3;
   localparam logic [1:0] CHANNEL_SPARE = 2'd3;

   localparam int ITEM_TOTAL       = 1850;
   localparam int HOLD_AT_ITEM     = 300;
   localparam int DRAIN_AT_ITEM    = 900;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES    = 30;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;

   int sent_by_kind [3];
   int sent_ignored;
   int useful_sent;
   bit hold_go;
   bit tx_calm;

   // Bounds last loaded per channel, used only to aim samples at useful values.
   int aim_low  [3];
   int aim_high [3];

   always #5 clock = ~clock;

   three_channel_minmax_calibrated_scaler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   three_channel_minmax_calibrated_scaler_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic req_type make_beat(input logic [1:0] kind, input logic [1:0] channel,
                                         input int sample, input int lo, input int hi);
      req_type beat;
      beat.kind       = kind;
      beat.channel    = channel;
      beat.sample     = 16'(sample);
      beat.bound_low  = 16'(lo);
      beat.bound_high = 16'(hi);
      return beat;
   endfunction

   // A value between two bounds, widened by a margin and held to the 16-bit range.
   function automatic int pick_near(input int a, input int b, input int margin);
      int mn;
      int mx;
      mn = ((a < b) ? a : b) - margin;
      mx = ((a < b) ? b : a) + margin;
      if (mn < -32768) mn = -32768;
      if (mx > 32767) mx = 32767;
      return mn + int'($urandom_range(0, mx - mn));
   endfunction

   function automatic int any_word();
      return int'($signed(16'($urandom())));
   endfunction

   // Random beat: mostly useful set, track and scale traffic, with some ignored codes.
   function automatic req_type random_beat();
      int       pick;
      int       style;
      int       ch;
      int       lo;
      int       hi;
      int       span;
      logic [1:0] kind;
      pick = $urandom_range(0, 99);
      ch   = $urandom_range(0, 2);
      if (pick < 8) begin
         if ($urandom_range(0, 1) == 0) begin
            kind = KIND_SPARE;
            ch   = $urandom_range(0, 3);
         end else begin
            kind = 2'($urandom_range(0, 2));
            ch   = int'(CHANNEL_SPARE);
         end
         return make_beat(kind, 2'(ch), any_word(), any_word(), any_word());
      end
      if (pick < 22) begin
         style = $urandom_range(0, 9);
         if (style < 3) begin
            lo = any_word();
            hi = any_word();
         end else if (style < 7) begin
            lo = $urandom_range(0, 4000) - 2000;
            hi = lo + int'($urandom_range(1, 3000));
         end else if (style == 7) begin
            lo = any_word();
            hi = lo;
         end else if (style == 8) begin
            hi = $urandom_range(0, 4000) - 2000;
            lo = hi + int'($urandom_range(1, 3000));
         end else begin
            lo = $urandom_range(0, 20000) - 10000;
            hi = lo + int'($urandom_range(1, 4));
         end
         aim_low[ch]  = lo;
         aim_high[ch] = hi;
         return make_beat(KIND_SET, 2'(ch), any_word(), lo, hi);
      end
      span = aim_high[ch] - aim_low[ch];
      if (span < 0) span = -span;
      if (pick < 40) begin
         return make_beat(KIND_TRACK, 2'(ch), pick_near(aim_low[ch], aim_high[ch], 200),
                          any_word(), any_word());
      end
      if ($urandom_range(0, 9) < 7) begin
         return make_beat(KIND_SCALE, 2'(ch),
                          pick_near(aim_low[ch], aim_high[ch], span / 10 + 5),
                          any_word(), any_word());
      end
      return make_beat(KIND_SCALE, 2'(ch), any_word(), any_word(), any_word());
   endfunction

   // Offers one request beat from the falling edge until it is taken.
   task automatic send_beat(input req_type beat);
      @(negedge clock);
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (beat.kind == KIND_SPARE || beat.channel == CHANNEL_SPARE) begin
         sent_ignored++;
      end else begin
         sent_by_kind[beat.kind]++;
         useful_sent++;
      end
   endtask

   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Response side: random stalls, calm stretches, and one long hold-off on request.
   initial begin
      int  stall_left;
      int  hold_left;
      int  cycle_no;
      bit  hold_taken;
      bit  rx_calm;
      stall_left = 0;
      hold_left  = 0;
      cycle_no   = 0;
      hold_taken = 1'b0;
      rx_calm    = 1'b0;
      forever begin
         @(negedge clock);
         cycle_no++;
         if (cycle_no % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Safety net for a hung run.
   initial begin
      #10_000_000;
      $display("three_channel_minmax_calibrated_scaler_test NOT OK");
      $finish;
   end

   initial begin
      for (int i = 0; i < 3; i++) begin
         aim_low[i]  = 0;
         aim_high[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: bounds still zero after reset, so scaling flags a range error.
      send_beat(make_beat(KIND_SCALE, 2'd0, 5, 0, 0));
      // Widest possible span and readings at its ends and middle.
      send_beat(make_beat(KIND_SET, 2'd0, 0, -32768, 32767));
      send_beat(make_beat(KIND_SCALE, 2'd0, -32768, 0, 0));
      send_beat(make_beat(KIND_SCALE, 2'd0, 32767, 0, 0));
      send_beat(make_beat(KIND_SCALE, 2'd0, 0, 0, 0));
      // Reversed bounds run the scale backwards and clamp at both ends.
      send_beat(make_beat(KIND_SET, 2'd1, 0, 1000, -1000));
      send_beat(make_beat(KIND_SCALE, 2'd1, 0, 0, 0));
      send_beat(make_beat(KIND_SCALE, 2'd1, 2000, 0, 0));
      send_beat(make_beat(KIND_SCALE, 2'd1, -5000, 0, 0));
      // Equal bounds, then tracking pulls them apart.
      send_beat(make_beat(KIND_SET, 2'd2, 0, 123, 123));
      send_beat(make_beat(KIND_SCALE, 2'd2, 123, 0, 0));
      send_beat(make_beat(KIND_TRACK, 2'd2, 100, 0, 0));
      send_beat(make_beat(KIND_TRACK, 2'd2, 200, 0, 0));
      send_beat(make_beat(KIND_TRACK, 2'd2, 150, 0, 0));
      send_beat(make_beat(KIND_SCALE, 2'd2, 150, 0, 0));
      send_beat(make_beat(KIND_TRACK, 2'd2, -32768, 0, 0));
      send_beat(make_beat(KIND_TRACK, 2'd2, 32767, 0, 0));
      send_beat(make_beat(KIND_SCALE, 2'd2, 0, 0, 0));
      send_beat(make_beat(KIND_SCALE, 2'd2, -1, -1, -1));
      // Codes the block must ignore, some with every field bit set.
      send_beat(make_beat(KIND_SET, CHANNEL_SPARE, -1, -1, -1));
      send_beat(make_beat(KIND_TRACK, CHANNEL_SPARE, -32768, 0, 0));
      send_beat(make_beat(KIND_SCALE, CHANNEL_SPARE, 32767, 0, 0));
      send_beat(make_beat(KIND_SPARE, 2'd0, -32768, -32768, -32768));
      send_beat(make_beat(KIND_SPARE, CHANNEL_SPARE, -1, -1, -1));
      send_beat(make_beat(KIND_SCALE, 2'd0, 16384, 0, 0));
      aim_low[0]  = -32768;
      aim_high[0] = 32767;
      aim_low[1]  = 1000;
      aim_high[1] = -1000;
      aim_low[2]  = -32768;
      aim_high[2] = 32767;

      // Random traffic with sender stalls in some stretches and none in others.
      tx_calm = 1'b0;
      while (useful_sent + sent_ignored < ITEM_TOTAL) begin
         if (useful_sent % 200 == 0) tx_calm = ($urandom_range(0, 2) == 0);
         if (useful_sent == HOLD_AT_ITEM && !hold_go) begin
            // Back-to-back beats while the response side holds off.
            hold_go = 1'b1;
            repeat (12) send_beat(random_beat());
         end else if (useful_sent == DRAIN_AT_ITEM) begin
            // Let the block drain completely before carrying on.
            idle_for(1);
            wait (pending_count == 0);
            idle_for(pick_gap());
            send_beat(random_beat());
         end else begin
            send_beat(random_beat());
            if (!tx_calm && $urandom_range(0, 2) == 0) idle_for(pick_gap());
         end
      end

      idle_for(1);
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d set, %0d tracking and %0d scaling beats plus %0d ignored codes;",
               sent_by_kind[KIND_SET], sent_by_kind[KIND_TRACK], sent_by_kind[KIND_SCALE],
               sent_ignored);
      $display("%0d responses checked, with a long response hold-off and a full drain.",
               checked_count);
      if (pending_count != 0) begin
         $display("%0d responses never arrived", pending_count);
      end
      if (fail_count == 0 && pending_count == 0) begin
         $display("three_channel_minmax_calibrated_scaler_test OK");
      end else begin
         $display("three_channel_minmax_calibrated_scaler_test NOT OK");
      end
      $finish;
   end

endmodule
